>>> sv/chunked_transfer_slot_tracker_macros.svh
// ----------------------------------------------------------------------------
// Chunked transfer slot tracker assertion macros
// Concurrent check wrappers that compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_TRANSFER_SLOT_TRACKER_MACROS_SVH
`define CHUNKED_TRANSFER_SLOT_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define CTST_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define CTST_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CTST_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define CTST_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

>>> sv/ctst_pkg.sv
// ----------------------------------------------------------------------------
// ctst_pkg
// Shared constants, codes and the slot record layout of the slot tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ctst_pkg;

  localparam int SLOTS  = 8;
  localparam int SLOT_W = $clog2(SLOTS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_SNAP_ID     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SNAP_BYTES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_XFERS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 3'd6;

  localparam logic [63:0] RST_SNAP_ID     = 64'd0;
  localparam logic [31:0] RST_SNAP_BYTES  = 32'd0;
  localparam logic [31:0] RST_CHUNK_BYTES = 32'd65536;
  localparam logic [31:0] RST_CHUNK_COUNT = 32'd0;
  localparam logic [6:0]  RST_MAX_XFERS   = 7'd8;
  localparam logic [63:0] RST_ACK_TIMEOUT = 64'd1000000;
  localparam logic [7:0]  RST_MAX_RETRIES = 8'd3;

  localparam logic [2:0] MODE_BEGIN = 3'd0;
  localparam logic [2:0] MODE_NEXT  = 3'd1;
  localparam logic [2:0] MODE_ACK   = 3'd2;
  localparam logic [2:0] MODE_ABORT = 3'd3;
  localparam logic [2:0] MODE_TICK  = 3'd4;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_NO_SNAPSHOT = 4'd1;
  localparam logic [3:0] ST_DUPLICATE   = 4'd2;
  localparam logic [3:0] ST_LIMIT       = 4'd3;
  localparam logic [3:0] ST_NO_SLOT     = 4'd4;
  localparam logic [3:0] ST_UNKNOWN     = 4'd5;
  localparam logic [3:0] ST_NOT_SENDING = 4'd6;
  localparam logic [3:0] ST_ALL_SENT    = 4'd7;
  localparam logic [3:0] ST_ACK_IGNORED = 4'd8;

  localparam logic [1:0] PH_SENDING  = 2'd0;
  localparam logic [1:0] PH_WAITING  = 2'd1;
  localparam logic [1:0] PH_COMPLETE = 2'd2;
  localparam logic [1:0] PH_FAILED   = 2'd3;

  typedef struct packed {
    logic [7:0]  node;
    logic [1:0]  phase;
    logic [31:0] chunk;
    logic [31:0] total;
    logic [7:0]  retries;
    logic [63:0] last_ack;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

endpackage

`default_nettype wire

>>> sv/chunked_transfer_slot_tracker.sv
// ----------------------------------------------------------------------------
// chunked_transfer_slot_tracker
// Stop-and-wait chunk delivery for a table of transfer slots kept in a RAM.
//
// Channel  Direction  Contents
// in_      slave      tuser: mode; tdata: node_id, chunk_index, now_us
// out_     master     tuser: status; tlast: is_last; tdata: result fields
// cfg_     write      register index and 64-bit data, no read-back
//
// Begin, next chunk, ack and abort each sweep the whole slot RAM, then run a
// multiply and an execute step; a timeout tick sweeps the RAM and checks each
// slot as it is read; an unused mode goes straight to the output step. The sweep
// reads one entry per cycle through the RAM's single read port. Reset clears the
// valid bits of all slots at once; no clearing pass is needed. A stalled result
// holds in the output register while the next transaction runs; that transaction
// waits with its result until the register is free, and only then is input taken.
// ----------------------------------------------------------------------------
`include "chunked_transfer_slot_tracker_macros.svh"
`default_nettype none

module chunked_transfer_slot_tracker
  import ctst_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire [2:0]             in_tuser,   // mode[2:0]
  input  wire [103:0]           in_tdata,   // node_id[7:0], chunk_index[39:8], now_us[103:40]
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [3:0]            out_tuser,  // status[3:0]
  output logic                  out_tlast,
  // slot_index[5:0], chunk_number[37:6], chunk_offset[69:38], chunk_length[101:70],
  // transfer_done[102], timed_out_count[109:103], active_count[116:110],
  // failed_count[148:117], zero fill[151:149]
  output logic [151:0]          out_tdata,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_MUL, S_EXEC, S_OUT} state_t;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

  state_t state_r, state_nxt;

  logic [63:0] snap_id_r, snap_id_nxt;
  logic [31:0] snap_bytes_r, snap_bytes_nxt;
  logic [31:0] chunk_bytes_r, chunk_bytes_nxt;
  logic [31:0] chunk_cnt_r, chunk_cnt_nxt;
  logic [6:0]  max_xfers_r, max_xfers_nxt;
  logic [63:0] ack_to_r, ack_to_nxt;
  logic [7:0]  max_retry_r, max_retry_nxt;

  logic [SLOTS-1:0]  act_r, act_nxt;
  logic [6:0]        active_r, active_nxt;
  logic [31:0]       failed_r, failed_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [SLOT_W:0]   cnt_r, cnt_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [SLOT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              hit_r, hit_nxt;

  logic [2:0]        mode_r, mode_nxt;
  logic [7:0]        node_r, node_nxt;
  logic [31:0]       idx_r, idx_nxt;
  logic [63:0]       now_r, now_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  slot_rec_t         rec_r, rec_nxt;
  logic [63:0]       off_r, off_nxt;
  logic [6:0]        tout_r, tout_nxt;

  logic [3:0]   res_status_r, res_status_nxt;
  logic [5:0]   res_slot_r, res_slot_nxt;
  logic [31:0]  res_cnum_r, res_cnum_nxt;
  logic [31:0]  res_coff_r, res_coff_nxt;
  logic [31:0]  res_clen_r, res_clen_nxt;
  logic         res_last_r, res_last_nxt;
  logic         res_done_r, res_done_nxt;
  logic [6:0]   res_tout_r, res_tout_nxt;

  logic [151:0] out_tdata_r, out_tdata_nxt;
  logic [3:0]   out_tuser_r, out_tuser_nxt;
  logic         out_tlast_r, out_tlast_nxt;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  slot_rec_t         ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  slot_rec_t         ram_rdata;

  logic              free_any;
  logic [SLOT_W-1:0] free_idx;
  logic [63:0]       elapsed;
  logic [7:0]        retry_inc;
  logic [63:0]       rem;
  logic [31:0]       clen;
  logic [31:0]       coff;
  logic              is_last;
  logic [31:0]       chunk_inc;
  logic              ack_done;
  logic [6:0]        active_dec;
  logic [31:0]       failed_inc;

  ctst_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = cnt_r[SLOT_W-1:0];

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign elapsed    = now_r - ram_rdata.last_ack;
  assign retry_inc  = (ram_rdata.retries == 8'hFF) ? 8'hFF : ram_rdata.retries + 8'd1;
  assign rem        = (off_r < {32'd0, snap_bytes_r}) ? {32'd0, snap_bytes_r} - off_r : 64'd0;
  assign clen       = (rem < {32'd0, chunk_bytes_r}) ? rem[31:0] : chunk_bytes_r;
  assign coff       = (off_r[63:32] != 32'd0) ? 32'hFFFF_FFFF : off_r[31:0];
  assign is_last    = ({1'b0, rec_r.chunk} + 33'd1) >= {1'b0, rec_r.total};
  assign chunk_inc  = (rec_r.chunk == 32'hFFFF_FFFF) ? rec_r.chunk : rec_r.chunk + 32'd1;
  assign ack_done   = chunk_inc >= rec_r.total;
  assign active_dec = (active_r != 7'd0) ? active_r - 7'd1 : active_r;
  assign failed_inc = (failed_r != 32'hFFFF_FFFF) ? failed_r + 32'd1 : failed_r;

  always_comb begin
    state_nxt       = state_r;
    snap_id_nxt     = snap_id_r;
    snap_bytes_nxt  = snap_bytes_r;
    chunk_bytes_nxt = chunk_bytes_r;
    chunk_cnt_nxt   = chunk_cnt_r;
    max_xfers_nxt   = max_xfers_r;
    ack_to_nxt      = ack_to_r;
    max_retry_nxt   = max_retry_r;
    act_nxt         = act_r;
    active_nxt      = active_r;
    failed_nxt      = failed_r;
    out_tvalid_nxt  = out_tvalid_r;
    cnt_nxt         = cnt_r;
    rd_vld_nxt      = rd_vld_r;
    rd_idx_nxt      = rd_idx_r;
    hit_nxt         = hit_r;
    mode_nxt        = mode_r;
    node_nxt        = node_r;
    idx_nxt         = idx_r;
    now_nxt         = now_r;
    slot_nxt        = slot_r;
    rec_nxt         = rec_r;
    off_nxt         = off_r;
    tout_nxt        = tout_r;
    res_status_nxt  = res_status_r;
    res_slot_nxt    = res_slot_r;
    res_cnum_nxt    = res_cnum_r;
    res_coff_nxt    = res_coff_r;
    res_clen_nxt    = res_clen_r;
    res_last_nxt    = res_last_r;
    res_done_nxt    = res_done_r;
    res_tout_nxt    = res_tout_r;
    out_tdata_nxt   = out_tdata_r;
    out_tuser_nxt   = out_tuser_r;
    out_tlast_nxt   = out_tlast_r;
    ram_we          = 1'b0;
    ram_waddr       = rd_idx_r;
    ram_wdata       = ram_rdata;

    if (cfg_we) begin
      case (cfg_index)
        CFG_SNAP_ID:     snap_id_nxt     = cfg_data;
        CFG_SNAP_BYTES:  snap_bytes_nxt  = cfg_data[31:0];
        CFG_CHUNK_BYTES: chunk_bytes_nxt = cfg_data[31:0];
        CFG_CHUNK_COUNT: chunk_cnt_nxt   = cfg_data[31:0];
        CFG_MAX_XFERS:   max_xfers_nxt   = cfg_data[6:0];
        CFG_ACK_TIMEOUT: ack_to_nxt      = cfg_data;
        CFG_MAX_RETRIES: max_retry_nxt   = cfg_data[7:0];
        default: ;
      endcase
    end

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt       = in_tuser;
          node_nxt       = in_tdata[7:0];
          idx_nxt        = in_tdata[39:8];
          now_nxt        = in_tdata[103:40];
          cnt_nxt        = '0;
          rd_vld_nxt     = 1'b0;
          hit_nxt        = 1'b0;
          tout_nxt       = '0;
          res_status_nxt = ST_OK;
          res_slot_nxt   = '0;
          res_cnum_nxt   = '0;
          res_coff_nxt   = '0;
          res_clen_nxt   = '0;
          res_last_nxt   = 1'b0;
          res_done_nxt   = 1'b0;
          res_tout_nxt   = '0;
          if (in_tuser inside {[MODE_BEGIN:MODE_TICK]}) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end

      S_SCAN: begin
        if (cnt_r < (SLOT_W + 1)'(SLOTS)) begin
          cnt_nxt    = cnt_r + 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r[SLOT_W-1:0];
        end else begin
          rd_vld_nxt = 1'b0;
        end
        if (rd_vld_r) begin
          if (mode_r == MODE_TICK) begin
            if (act_r[rd_idx_r] && ram_rdata.phase == PH_WAITING && elapsed > ack_to_r) begin
              ram_we            = 1'b1;
              ram_wdata.retries = retry_inc;
              if (retry_inc >= max_retry_r) begin
                ram_wdata.phase   = PH_FAILED;
                act_nxt[rd_idx_r] = 1'b0;
                active_nxt        = active_dec;
                failed_nxt        = failed_inc;
                tout_nxt          = tout_r + 7'd1;
              end else begin
                ram_wdata.phase = PH_SENDING;
              end
            end
            if (rd_idx_r == LAST_IDX) begin
              res_tout_nxt = tout_nxt;
              state_nxt    = S_OUT;
            end
          end else begin
            if (!hit_r && act_r[rd_idx_r] && ram_rdata.node == node_r) begin
              hit_nxt  = 1'b1;
              slot_nxt = rd_idx_r;
              rec_nxt  = ram_rdata;
            end
            if (rd_idx_r == LAST_IDX) begin
              state_nxt = S_MUL;
            end
          end
        end
      end

      S_MUL: begin
        off_nxt   = 64'(rec_r.chunk) * 64'(chunk_bytes_r);
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        ram_waddr = slot_r;
        ram_wdata = rec_r;
        case (mode_r)
          MODE_BEGIN: begin
            if (snap_id_r == 64'd0) begin
              res_status_nxt = ST_NO_SNAPSHOT;
            end else if (hit_r) begin
              res_status_nxt = ST_DUPLICATE;
            end else if (active_r >= max_xfers_r) begin
              res_status_nxt = ST_LIMIT;
            end else if (!free_any) begin
              res_status_nxt = ST_NO_SLOT;
            end else begin
              ram_we             = 1'b1;
              ram_waddr          = free_idx;
              ram_wdata.node     = node_r;
              ram_wdata.phase    = PH_SENDING;
              ram_wdata.chunk    = '0;
              ram_wdata.total    = chunk_cnt_r;
              ram_wdata.retries  = '0;
              ram_wdata.last_ack = now_r;
              act_nxt[free_idx]  = 1'b1;
              active_nxt         = active_r + 7'd1;
              res_slot_nxt       = 6'(free_idx);
            end
          end
          MODE_NEXT: begin
            if (!hit_r) begin
              res_status_nxt = ST_UNKNOWN;
            end else if (rec_r.phase != PH_SENDING) begin
              res_status_nxt = ST_NOT_SENDING;
              res_slot_nxt   = 6'(slot_r);
            end else if (rec_r.chunk >= rec_r.total) begin
              res_status_nxt = ST_ALL_SENT;
              res_slot_nxt   = 6'(slot_r);
            end else begin
              ram_we          = 1'b1;
              ram_wdata.phase = PH_WAITING;
              res_slot_nxt    = 6'(slot_r);
              res_cnum_nxt    = rec_r.chunk;
              res_coff_nxt    = coff;
              res_clen_nxt    = clen;
              res_last_nxt    = is_last;
            end
          end
          MODE_ACK: begin
            if (!hit_r) begin
              res_status_nxt = ST_UNKNOWN;
            end else if (idx_r != rec_r.chunk) begin
              res_status_nxt = ST_ACK_IGNORED;
              res_slot_nxt   = 6'(slot_r);
            end else begin
              ram_we             = 1'b1;
              ram_wdata.chunk    = chunk_inc;
              ram_wdata.last_ack = now_r;
              ram_wdata.retries  = '0;
              ram_wdata.phase    = ack_done ? PH_COMPLETE : PH_SENDING;
              res_slot_nxt       = 6'(slot_r);
              res_done_nxt       = ack_done;
            end
          end
          MODE_ABORT: begin
            if (!hit_r) begin
              res_status_nxt = ST_UNKNOWN;
            end else begin
              ram_we          = 1'b1;
              ram_wdata.phase = PH_FAILED;
              act_nxt[slot_r] = 1'b0;
              active_nxt      = active_dec;
              failed_nxt      = failed_inc;
              res_slot_nxt    = 6'(slot_r);
            end
          end
          default: ;
        endcase
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = res_status_r;
          out_tlast_nxt  = res_last_r;
          out_tdata_nxt  = {3'b000, failed_r, active_r, res_tout_r, res_done_r,
                            res_clen_r, res_coff_r, res_cnum_r, res_slot_r};
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      snap_id_r     <= RST_SNAP_ID;
      snap_bytes_r  <= RST_SNAP_BYTES;
      chunk_bytes_r <= RST_CHUNK_BYTES;
      chunk_cnt_r   <= RST_CHUNK_COUNT;
      max_xfers_r   <= RST_MAX_XFERS;
      ack_to_r      <= RST_ACK_TIMEOUT;
      max_retry_r   <= RST_MAX_RETRIES;
      act_r         <= '0;
      active_r      <= '0;
      failed_r      <= '0;
      out_tvalid_r  <= 1'b0;
      cnt_r         <= '0;
      rd_vld_r      <= 1'b0;
      rd_idx_r      <= '0;
      hit_r         <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      snap_id_r     <= snap_id_nxt;
      snap_bytes_r  <= snap_bytes_nxt;
      chunk_bytes_r <= chunk_bytes_nxt;
      chunk_cnt_r   <= chunk_cnt_nxt;
      max_xfers_r   <= max_xfers_nxt;
      ack_to_r      <= ack_to_nxt;
      max_retry_r   <= max_retry_nxt;
      act_r         <= act_nxt;
      active_r      <= active_nxt;
      failed_r      <= failed_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
      cnt_r         <= cnt_nxt;
      rd_vld_r      <= rd_vld_nxt;
      rd_idx_r      <= rd_idx_nxt;
      hit_r         <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    node_r       <= node_nxt;
    idx_r        <= idx_nxt;
    now_r        <= now_nxt;
    slot_r       <= slot_nxt;
    rec_r        <= rec_nxt;
    off_r        <= off_nxt;
    tout_r       <= tout_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_cnum_r   <= res_cnum_nxt;
    res_coff_r   <= res_coff_nxt;
    res_clen_r   <= res_clen_nxt;
    res_last_r   <= res_last_nxt;
    res_done_r   <= res_done_nxt;
    res_tout_r   <= res_tout_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
    out_tlast_r  <= out_tlast_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;
  assign out_tdata  = out_tdata_r;

  // The active counter always equals the number of occupied slots.
  `CTST_ASSERT_IMP(a_active_matches, clk, rst_n, 1'b1, active_r == 7'($countones(act_r)))
  // A node found by the lookup sweep is still occupied when the operation executes.
  `CTST_ASSERT_IMP(a_hit_active, clk, rst_n, state_r == S_EXEC && hit_r, act_r[slot_r])
  // The failure counter never moves backward.
  `CTST_ASSERT_NXT(a_failed_mono, clk, rst_n, 1'b1, failed_r >= $past(failed_r))
  // No new transaction is taken while a sweep is running.
  `CTST_ASSERT_IMP(a_scan_busy, clk, rst_n, state_r == S_SCAN, !in_tready)

endmodule

`default_nettype wire

>>> sv/ctst_ram.sv
// ----------------------------------------------------------------------------
// ctst_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ctst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
